// File: hw/rtl/sbsa_pkg.sv
// slab bitmap slot allocator: shared types and constants
// no dependencies; every other file of the block but sbsa_ram uses this package
`default_nettype none

package sbsa_pkg;

  localparam int ADDR_BITS   = 64;
  localparam int CHUNK_W     = 17;
  localparam int HDR_W       = 13;
  localparam int SLOTS_W     = 9;
  localparam int CNT_W       = 9;
  localparam int SLOT_OUT_W  = 8;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 8;

  // bitmap word geometry
  localparam int WORD_W      = 16;
  localparam int WBIT_W      = 4;

  // divider: offset below 511 * 131072, quotient below 512
  localparam int OFF_W       = 26;
  localparam int Q_W         = 9;
  localparam int DIV_CNT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BASE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 8'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ALLOC  = 3'd0,
    STAT_FREED  = 3'd1,
    STAT_NOSLOT = 3'd2,
    STAT_IGNORE = 3'd3,
    STAT_BADBND = 3'd4,
    STAT_DOUBLE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RANGE,
    S_BOUND,
    S_DIV,
    S_SCAN,
    S_SWEEP,
    S_UPDATE,
    S_MUL,
    S_ADD1,
    S_ADD2,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [CNT_W-1:0]  used;
    logic [WBIT_W-1:0] fbit;
    logic [WORD_W-1:0] word;
  } scan_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/sbsa_req_if.sv
// request channel: kind and payload address
// depends on sbsa_pkg
`default_nettype none

interface sbsa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [sbsa_pkg::ADDR_BITS-1:0] payload_address;

  modport source (output valid, output kind, output payload_address, input ready);
  modport sink   (input valid, input kind, input payload_address, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sbsa_rsp_if.sv
// result channel: status, address, slot and occupancy marks
// depends on sbsa_pkg
`default_nettype none

interface sbsa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [sbsa_pkg::STATUS_W-1:0]   status;
  logic [sbsa_pkg::ADDR_BITS-1:0]  result_address;
  logic [sbsa_pkg::SLOT_OUT_W-1:0] slot_index;
  logic [sbsa_pkg::CNT_W-1:0]      free_slots;
  logic                            all_taken;
  logic                            slab_empty;

  modport source (output valid, output status, output result_address, output slot_index,
                  output free_slots, output all_taken, output slab_empty, input ready);
  modport sink   (input valid, input status, input result_address, input slot_index,
                  input free_slots, input all_taken, input slab_empty, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sbsa_cfg_if.sv
// configuration write channel: register index and data
// depends on sbsa_pkg
`default_nettype none

interface sbsa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sbsa_pkg::CFG_IDX_W-1:0] index;
  logic [sbsa_pkg::ADDR_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sbsa_ram.sv
// generic single-clock ram, one write port, one read port, registered read
// no dependencies
`default_nettype none

module sbsa_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sbsa_div.sv
// restoring divider: slab offset by chunk size, one quotient bit per cycle
// depends on sbsa_pkg
`default_nettype none

module sbsa_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [sbsa_pkg::OFF_W-1:0]      dividend,
  input  logic [sbsa_pkg::CHUNK_W-1:0]    divisor,
  output logic                            done,
  output logic [sbsa_pkg::Q_W-1:0]        quotient,
  output logic [sbsa_pkg::CHUNK_W-1:0]    remainder
);

  localparam int OFF_W = sbsa_pkg::OFF_W;
  localparam int DVS_W = sbsa_pkg::OFF_W + 1;
  localparam int Q_W   = sbsa_pkg::Q_W;
  localparam int CW    = sbsa_pkg::DIV_CNT_W;

  logic             running;
  logic [CW-1:0]    cnt;
  logic [OFF_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs;
  logic [Q_W-1:0]   q;
  logic [DVS_W-1:0] rem_x;
  logic             ge;

  assign rem_x     = DVS_W'(rem_r);
  assign ge        = rem_x >= dvs;
  assign done      = running && (cnt == '0);
  assign quotient  = q;
  assign remainder = sbsa_pkg::CHUNK_W'(rem_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= CW'(Q_W);
    end else if (done) begin
      running <= 1'b0;
    end else if (running) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dvs   <= DVS_W'(divisor) << (Q_W - 1);
      q     <= '0;
    end else if (running && !done) begin
      rem_r <= ge ? OFF_W'(rem_x - dvs) : rem_r;
      q     <= {q[Q_W-2:0], ge};
      dvs   <= dvs >> 1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sbsa_scan.sv
// bitmap sweep: reads every word, counts used active slots, finds the
// lowest free slot or captures the word of a slot being freed; uses sbsa_pkg
`default_nettype none

module sbsa_scan #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         alloc,
  input  logic [sbsa_pkg::CNT_W-1:0]   n_act,
  input  logic [ADDR_W-1:0]            tgt,
  output logic                         rd_en,
  output logic [ADDR_W-1:0]            rd_addr,
  input  logic [sbsa_pkg::WORD_W-1:0]  rd_data,
  output logic [ADDR_W-1:0]            found_addr,
  output sbsa_pkg::scan_stat_t         stat
);

  localparam int WORD_W = sbsa_pkg::WORD_W;
  localparam int BIT_W  = sbsa_pkg::WBIT_W;
  localparam int CNT_W  = sbsa_pkg::CNT_W;
  localparam int IDX_W  = 16;
  localparam int POP_W  = BIT_W + 1;

  logic                busy;
  logic [ADDR_W:0]     issue_ptr;
  logic                rd_vld;
  logic [ADDR_W-1:0]   rd_addr_q;
  logic [CNT_W-1:0]    cnt;
  logic                found;
  logic [BIT_W-1:0]    fbit;
  logic [WORD_W-1:0]   word;
  logic                issuing;
  logic                done;
  logic [WORD_W-1:0]   mask;
  logic [WORD_W-1:0]   used_m;
  logic [WORD_W-1:0]   free_m;
  logic [POP_W-1:0]    pop;
  logic [BIT_W-1:0]    first;

  assign issuing = busy && (issue_ptr != (ADDR_W + 1)'(DEPTH));
  assign rd_en   = issuing;
  assign rd_addr = issue_ptr[ADDR_W-1:0];
  assign done    = busy && !issuing && !rd_vld;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      mask[b] = IDX_W'({rd_addr_q, BIT_W'(b)}) < IDX_W'(n_act);
    end
    used_m = rd_data & mask;
    free_m = ~rd_data & mask;
    pop    = '0;
    first  = '0;
    for (int b = 0; b < WORD_W; b++) begin
      pop = pop + POP_W'(used_m[b]);
    end
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_m[b]) begin
        first = BIT_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      issue_ptr <= '0;
      rd_vld    <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (start) begin
        busy      <= 1'b1;
        issue_ptr <= '0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (issuing) begin
        issue_ptr <= issue_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    if (start) begin
      cnt   <= '0;
      found <= 1'b0;
    end else if (rd_vld) begin
      cnt <= cnt + CNT_W'(pop);
      if (alloc && !found && (free_m != '0)) begin
        found      <= 1'b1;
        found_addr <= rd_addr_q;
        fbit       <= first;
        word       <= rd_data;
      end
      if (!alloc && (rd_addr_q == tgt)) begin
        word <= rd_data;
      end
    end
  end

  assign stat.done  = done;
  assign stat.found = found;
  assign stat.used  = cnt;
  assign stat.fbit  = fbit;
  assign stat.word  = word;

endmodule

`default_nettype wire

// File: hw/rtl/slab_bitmap_slot_allocator_core.sv
// slab slot allocator top: config registers, request sequencer, bitmap ram
// depends on sbsa_pkg, the three channel interfaces, sbsa_ram, sbsa_div, sbsa_scan
//
//  channel  dir  beat contents
//  -------  ---  -----------------------------------------------------------
//  req      in   kind, payload_address
//  rsp      out  status, result_address, slot_index, free_slots, all_taken,
//                slab_empty
//  cfg      in   index (0 base, 1 chunk, 2 header, 3 slots), data; ready
//                always high
//
// one request at a time; the time a beat takes is set by the word-serial sweep
// of the bitmap ram, plus the 9-step divider on frees that pass the range check.
// after reset a clearing pass zeroes the ram word by word with req ready low.
// a result held by rsp back-pressure lets the next request in; its own result
// waits in the final state until the output register frees.
`default_nettype none

module slab_bitmap_slot_allocator_core #(
  parameter int MAX_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  sbsa_req_if.sink    req,
  sbsa_rsp_if.source  rsp,
  sbsa_cfg_if.sink    cfg
);

  localparam int WORD_W = sbsa_pkg::WORD_W;
  localparam int BIT_W  = sbsa_pkg::WBIT_W;
  localparam int CNT_W  = sbsa_pkg::CNT_W;
  localparam int AB     = sbsa_pkg::ADDR_BITS;
  localparam int DEPTH  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int PROD_W = SLOT_W + sbsa_pkg::CHUNK_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SPAN_W = sbsa_pkg::OFF_W + 1;
  localparam logic [12:0] MAX_L = 13'(MAX_SLOTS);

  sbsa_pkg::state_t state, state_next;

  // configuration
  logic [AB-1:0]                    slab_base;
  logic [sbsa_pkg::CHUNK_W-1:0]     chunk_bytes;
  logic [sbsa_pkg::HDR_W-1:0]       header_bytes;
  logic [sbsa_pkg::SLOTS_W-1:0]     slots_in_use;
  logic [CNT_W-1:0]                 n_act;
  logic [SPAN_W-1:0]                span;

  // request datapath
  logic [ADDR_W-1:0]     clr_ptr;
  logic                  is_free;
  logic [AB-1:0]         addr_in;
  logic [AB-1:0]         off;
  logic                  ign;
  logic                  chk_ok;
  sbsa_pkg::status_t     stat;
  logic [SLOT_W-1:0]     slot;
  logic [CNT_W-1:0]      used_after;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      osum;
  logic [AB-1:0]         addr_out;
  logic                  out_range;
  logic [CNT_W-1:0]      free_n;

  // result register
  logic                               rsp_valid;
  sbsa_pkg::status_t                  rsp_status;
  logic [AB-1:0]                      rsp_addr;
  logic [sbsa_pkg::SLOT_OUT_W-1:0]    rsp_slot;
  logic [CNT_W-1:0]                   rsp_free;
  logic                               rsp_full;
  logic                               rsp_empty;
  logic                               rsp_load;

  // ram and unit hookup
  logic                   ram_wr_en;
  logic [ADDR_W-1:0]      ram_wr_addr;
  logic [WORD_W-1:0]      ram_wr_data;
  logic                   ram_rd_en;
  logic [ADDR_W-1:0]      ram_rd_addr;
  logic [WORD_W-1:0]      ram_rd_data;
  logic                   scan_start;
  logic [ADDR_W-1:0]      scan_addr;
  logic [ADDR_W-1:0]      tgt_addr;
  logic [BIT_W-1:0]       bpos;
  sbsa_pkg::scan_stat_t   scan;
  logic                   div_start;
  logic                   div_done;
  logic [sbsa_pkg::Q_W-1:0]     div_q;
  logic [sbsa_pkg::CHUNK_W-1:0] div_rem;
  logic [SLOT_W-1:0]      alloc_slot;
  logic                   free_hit;

  assign n_act      = (13'(slots_in_use) > MAX_L) ? CNT_W'(MAX_L) : slots_in_use;
  assign out_range  = ign || (off < AB'(header_bytes)) || (off >= AB'(span));
  assign tgt_addr   = ADDR_W'(slot >> BIT_W);
  assign bpos       = BIT_W'(slot);
  assign alloc_slot = SLOT_W'({scan_addr, scan.fbit});
  assign free_hit   = scan.word[bpos];
  assign free_n     = n_act - used_after;
  assign rsp_load   = (state == sbsa_pkg::S_RESULT) && (!rsp_valid || rsp.ready);

  sbsa_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  sbsa_scan #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (scan_start),
    .alloc      (!is_free),
    .n_act      (n_act),
    .tgt        (tgt_addr),
    .rd_en      (ram_rd_en),
    .rd_addr    (ram_rd_addr),
    .rd_data    (ram_rd_data),
    .found_addr (scan_addr),
    .stat       (scan)
  );

  sbsa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (off[sbsa_pkg::OFF_W-1:0]),
    .divisor   (chunk_bytes),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sbsa_pkg::S_CLEAR: begin
        if (clr_ptr == ADDR_W'(DEPTH - 1)) state_next = sbsa_pkg::S_IDLE;
      end
      sbsa_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = (req.kind == sbsa_pkg::KIND_FREE) ? sbsa_pkg::S_RANGE
                                                         : sbsa_pkg::S_SCAN;
        end
      end
      sbsa_pkg::S_RANGE:  state_next = sbsa_pkg::S_BOUND;
      sbsa_pkg::S_BOUND:  state_next = out_range ? sbsa_pkg::S_SCAN : sbsa_pkg::S_DIV;
      sbsa_pkg::S_DIV: begin
        if (div_done) state_next = sbsa_pkg::S_SCAN;
      end
      sbsa_pkg::S_SCAN:   state_next = sbsa_pkg::S_SWEEP;
      sbsa_pkg::S_SWEEP: begin
        if (scan.done) state_next = sbsa_pkg::S_UPDATE;
      end
      sbsa_pkg::S_UPDATE: begin
        state_next = (!is_free && scan.found) ? sbsa_pkg::S_MUL : sbsa_pkg::S_RESULT;
      end
      sbsa_pkg::S_MUL:    state_next = sbsa_pkg::S_ADD1;
      sbsa_pkg::S_ADD1:   state_next = sbsa_pkg::S_ADD2;
      sbsa_pkg::S_ADD2:   state_next = sbsa_pkg::S_RESULT;
      sbsa_pkg::S_RESULT: begin
        if (rsp_load) state_next = sbsa_pkg::S_IDLE;
      end
      default:            state_next = sbsa_pkg::S_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready   = 1'b0;
    scan_start  = 1'b0;
    div_start   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = clr_ptr;
    ram_wr_data = '0;
    case (state)
      sbsa_pkg::S_CLEAR: begin
        ram_wr_en = 1'b1;
      end
      sbsa_pkg::S_IDLE:  req.ready  = 1'b1;
      sbsa_pkg::S_BOUND: div_start  = !out_range;
      sbsa_pkg::S_SCAN:  scan_start = 1'b1;
      sbsa_pkg::S_UPDATE: begin
        if (!is_free) begin
          ram_wr_en   = scan.found;
          ram_wr_addr = scan_addr;
          ram_wr_data = scan.word | (WORD_W'(1) << scan.fbit);
        end else begin
          ram_wr_en   = chk_ok && free_hit;
          ram_wr_addr = tgt_addr;
          ram_wr_data = scan.word & ~(WORD_W'(1) << bpos);
        end
      end
      default: begin
      end
    endcase
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sbsa_pkg::S_CLEAR;
      clr_ptr      <= '0;
      rsp_valid    <= 1'b0;
      slab_base    <= '0;
      chunk_bytes  <= 17'd64;
      header_bytes <= 13'd32;
      slots_in_use <= 9'd256;
    end else begin
      state <= state_next;
      if (state == sbsa_pkg::S_CLEAR) begin
        clr_ptr <= clr_ptr + 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg.valid) begin
        case (cfg.index)
          sbsa_pkg::CFG_SLAB_BASE:    slab_base    <= cfg.data;
          sbsa_pkg::CFG_CHUNK_BYTES:  chunk_bytes  <= cfg.data[sbsa_pkg::CHUNK_W-1:0];
          sbsa_pkg::CFG_HEADER_BYTES: header_bytes <= cfg.data[sbsa_pkg::HDR_W-1:0];
          sbsa_pkg::CFG_SLOTS_IN_USE: slots_in_use <= cfg.data[sbsa_pkg::SLOTS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    span <= SPAN_W'(n_act) * SPAN_W'(chunk_bytes);
    case (state)
      sbsa_pkg::S_IDLE: begin
        if (req.valid) begin
          is_free  <= (req.kind == sbsa_pkg::KIND_FREE);
          addr_in  <= req.payload_address;
          slot     <= '0;
          addr_out <= '0;
          chk_ok   <= 1'b0;
          stat     <= sbsa_pkg::STAT_IGNORE;
        end
      end
      sbsa_pkg::S_RANGE: begin
        off <= addr_in - slab_base;
        ign <= (addr_in == '0) || (addr_in < slab_base);
      end
      sbsa_pkg::S_DIV: begin
        if (div_done) begin
          if (div_rem != sbsa_pkg::CHUNK_W'(header_bytes)) begin
            stat <= sbsa_pkg::STAT_BADBND;
          end else begin
            chk_ok <= 1'b1;
            slot   <= SLOT_W'(div_q);
          end
        end
      end
      sbsa_pkg::S_UPDATE: begin
        used_after <= scan.used;
        if (!is_free) begin
          if (scan.found) begin
            stat       <= sbsa_pkg::STAT_ALLOC;
            slot       <= alloc_slot;
            used_after <= scan.used + 1'b1;
          end else begin
            stat <= sbsa_pkg::STAT_NOSLOT;
          end
        end else if (chk_ok) begin
          if (free_hit) begin
            stat       <= sbsa_pkg::STAT_FREED;
            used_after <= scan.used - 1'b1;
          end else begin
            stat <= sbsa_pkg::STAT_DOUBLE;
          end
        end
      end
      sbsa_pkg::S_MUL:  prod     <= PROD_W'(slot) * PROD_W'(chunk_bytes);
      sbsa_pkg::S_ADD1: osum     <= SUM_W'(prod) + SUM_W'(header_bytes);
      sbsa_pkg::S_ADD2: addr_out <= slab_base + AB'(osum);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_status <= stat;
      rsp_addr   <= addr_out;
      rsp_slot   <= sbsa_pkg::SLOT_OUT_W'(slot);
      rsp_free   <= free_n;
      rsp_full   <= (free_n == '0);
      rsp_empty  <= (stat == sbsa_pkg::STAT_FREED) && (used_after == '0);
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.result_address = rsp_addr;
  assign rsp.slot_index     = rsp_slot;
  assign rsp.free_slots     = rsp_free;
  assign rsp.all_taken      = rsp_full;
  assign rsp.slab_empty     = rsp_empty;

endmodule

`default_nettype wire

// File: hw/rtl/sbsa_chk.sv
// port-level checks for the slab allocator, bound to the top level
// depends on sbsa_pkg and slab_bitmap_slot_allocator_core
`default_nettype none

module sbsa_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [sbsa_pkg::STATUS_W-1:0]   rsp_status,
  input logic [sbsa_pkg::ADDR_BITS-1:0]  rsp_result_address,
  input logic [sbsa_pkg::CNT_W-1:0]      rsp_free_slots,
  input logic                            rsp_all_taken,
  input logic                            rsp_slab_empty
);

  // clearing pass keeps requests out right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request accepted during clearing pass");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                && $stable(rsp_result_address))
    else $error("result beat changed while stalled");

  a_full_mark: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_all_taken == (rsp_free_slots == '0))
    else $error("full mark disagrees with free count");

  a_empty_mark: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_slab_empty |->
      rsp_status == sbsa_pkg::STAT_FREED && rsp_free_slots != '0)
    else $error("empty mark without a successful free");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != sbsa_pkg::STAT_ALLOC |-> rsp_result_address == '0)
    else $error("address on a result that is not an allocation");

endmodule

bind slab_bitmap_slot_allocator_core sbsa_chk u_sbsa_chk (
  .clk                (clk),
  .rst                (rst),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_result_address (rsp.result_address),
  .rsp_free_slots     (rsp.free_slots),
  .rsp_all_taken      (rsp.all_taken),
  .rsp_slab_empty     (rsp.slab_empty)
);

`default_nettype wire

// File: tb/slab_bitmap_slot_allocator_core_tb.sv
// testbench for slab_bitmap_slot_allocator_core: drives allocate and free beats,
// predicts each result from a bitmap model and checks it field by field
// depends on sbsa_pkg, sbsa_req_if, sbsa_rsp_if, sbsa_cfg_if and the block rtl

module slab_bitmap_slot_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbsa_pkg::*;

  localparam int SLOTS        = 256;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 50;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    status_t                status;
    logic [ADDR_BITS-1:0]   address;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [CNT_W-1:0]       free_n;
    logic                   full;
    logic                   empty;
  } slab_result_t;

  class slab_ledger;
    logic [ADDR_BITS-1:0] base;
    logic [CHUNK_W-1:0]   chunk;
    logic [HDR_W-1:0]     header;
    logic [SLOTS_W-1:0]   slots;
    bit                   used_map[SLOTS];
    slab_result_t         awaited[$];
    int                   errors;

    function new();
      base = '0;
      chunk = 17'd64;
      header = 13'd32;
      slots = 9'd256;
      foreach (used_map[i]) used_map[i] = 1'b0;
      errors = 0;
    endfunction

    function int unsigned active_slots();
      return (slots > SLOTS) ? SLOTS : slots;
    endfunction

    function logic [ADDR_BITS-1:0] payload_of(int unsigned s);
      return base + 64'(s) * 64'(chunk) + 64'(header);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_BITS-1:0] data);
      case (idx)
        CFG_SLAB_BASE:    base = data;
        CFG_CHUNK_BYTES:  chunk = data[CHUNK_W-1:0];
        CFG_HEADER_BYTES: header = data[HDR_W-1:0];
        CFG_SLOTS_IN_USE: slots = data[SLOTS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic is_free, logic [ADDR_BITS-1:0] addr);
      slab_result_t r;
      int unsigned n, in_use, s;
      logic [ADDR_BITS-1:0] off, span;
      bit found;
      n = active_slots();
      r = '0;
      found = 1'b0;
      if (is_free == KIND_ALLOC) begin
        r.status = STAT_NOSLOT;
        for (int i = 0; i < n && !found; i++) begin
          if (!used_map[i]) begin
            used_map[i] = 1'b1;
            found = 1'b1;
            r.status = STAT_ALLOC;
            r.slot = SLOT_OUT_W'(i);
            r.address = payload_of(i);
          end
        end
      end else begin
        span = 64'(n) * 64'(chunk);
        off = addr - base;
        if (addr == '0 || addr < base || off < 64'(header) || off >= span) begin
          r.status = STAT_IGNORE;
        end else if (off % 64'(chunk) != 64'(header)) begin
          r.status = STAT_BADBND;
        end else begin
          s = int'(off / 64'(chunk));
          r.slot = SLOT_OUT_W'(s);
          if (used_map[s]) begin
            used_map[s] = 1'b0;
            r.status = STAT_FREED;
          end else begin
            r.status = STAT_DOUBLE;
          end
        end
      end
      in_use = 0;
      for (int i = 0; i < n; i++) if (used_map[i]) in_use++;
      r.free_n = CNT_W'(n - in_use);
      r.full = (n == in_use);
      r.empty = (r.status == STAT_FREED) && (in_use == 0);
      awaited.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_result(slab_result_t got);
      slab_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited, status %0d", got.status));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.address !== want.address)
        report($sformatf("result_address %h, want %h", got.address, want.address));
      if (got.slot !== want.slot)
        report($sformatf("slot_index %0d, want %0d", got.slot, want.slot));
      if (got.free_n !== want.free_n)
        report($sformatf("free_slots %0d, want %0d", got.free_n, want.free_n));
      if (got.full !== want.full)
        report($sformatf("all_taken %b, want %b", got.full, want.full));
      if (got.empty !== want.empty)
        report($sformatf("slab_empty %b, want %b", got.empty, want.empty));
    endtask
  endclass

  logic clk;
  logic rst;
  sbsa_req_if req ();
  sbsa_rsp_if rsp ();
  sbsa_cfg_if cfg ();

  slab_ledger  ledger = new();
  bit          no_idle;
  bit          hold_rsp;
  int unsigned cycle_count;

  slab_bitmap_slot_allocator_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(logic is_free, logic [ADDR_BITS-1:0] addr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind <= is_free;
    req.payload_address <= addr;
    do @(posedge clk); while (req.ready !== 1'b1);
    ledger.note_request(is_free, addr);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_BITS-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    ledger.write_register(idx, data);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ADDR_BITS-1:0] pick_free_address();
    int unsigned n, roll;
    int unsigned held[$];
    n = ledger.active_slots();
    for (int i = 0; i < n; i++) if (ledger.used_map[i]) held.push_back(i);
    roll = $urandom_range(0, 99);
    if (roll < 45 && held.size() > 0)
      return ledger.payload_of(held[$urandom_range(0, held.size() - 1)]);
    if (roll < 65) return ledger.payload_of($urandom_range(0, n + 1));
    if (roll < 80) return ledger.payload_of($urandom_range(0, n)) ^ 64'($urandom_range(1, 15));
    if (roll < 90) return {$urandom, $urandom};
    if (roll < 95) return '0;
    if (roll < 98) return ledger.base + 64'($urandom_range(0, ledger.header));
    return ledger.base - 64'd1;
  endfunction

  task automatic run_phase(int items, int alloc_pct);
    repeat (items) begin
      if ($urandom_range(0, 99) < alloc_pct) send_request(KIND_ALLOC, {$urandom, $urandom});
      else send_request(KIND_FREE, pick_free_address());
    end
    settle();
  endtask

  task automatic random_config();
    logic [ADDR_BITS-1:0] base;
    int unsigned chunk, header, slots, roll;
    roll = $urandom_range(0, 3);
    case (roll)
      0: base = '0;
      1: base = {$urandom, $urandom};
      2: base = 64'($urandom);
      default: base = {32'hFFFF_FFFF, $urandom};
    endcase
    chunk = 8 * $urandom_range(1, ($urandom_range(0, 3) == 0) ? 8192 : 32);
    if ($urandom_range(0, 4) == 0) header = $urandom_range(0, 4096);
    else header = $urandom_range(0, (chunk - 1 > 4096) ? 4096 : chunk - 1);
    roll = $urandom_range(0, 9);
    if (roll < 7) slots = $urandom_range(1, 16);
    else if (roll == 7) slots = 256;
    else if (roll == 8) slots = $urandom_range(17, 255);
    else slots = $urandom_range(257, 511);
    write_reg(CFG_SLAB_BASE, base);
    write_reg(CFG_CHUNK_BYTES, 64'(chunk));
    write_reg(CFG_HEADER_BYTES, 64'(header));
    write_reg(CFG_SLOTS_IN_USE, 64'(slots));
  endtask

  initial begin : result_sink
    slab_result_t got;
    int gap;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_rsp = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
          rsp.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      got.status = status_t'(rsp.status);
      got.address = rsp.result_address;
      got.slot = rsp.slot_index;
      got.free_n = rsp.free_slots;
      got.full = rsp.all_taken;
      got.empty = rsp.slab_empty;
      ledger.check_result(got);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("slab_bitmap_slot_allocator_core_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    no_idle = 1'b0;
    hold_rsp = 1'b0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.kind <= KIND_ALLOC;
    req.payload_address <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset layout: base 0, 64-byte chunks, 32-byte header, 256 slots
    send_request(KIND_FREE, 64'd0);
    send_request(KIND_FREE, 64'd32);
    repeat (3) send_request(KIND_ALLOC, {$urandom, $urandom});
    send_request(KIND_FREE, 64'd97);
    send_request(KIND_FREE, 64'd16);
    send_request(KIND_FREE, 64'd16416);
    send_request(KIND_FREE, '1);
    send_request(KIND_FREE, 64'd96);
    send_request(KIND_FREE, 64'd96);
    send_request(KIND_ALLOC, {$urandom, $urandom});
    send_request(KIND_FREE, 64'd32);
    send_request(KIND_FREE, 64'd96);
    send_request(KIND_FREE, 64'd160);
    settle();

    // fill a four-slot slab past full
    write_reg(CFG_SLOTS_IN_USE, 64'd4);
    repeat (5) send_request(KIND_ALLOC, {$urandom, $urandom});
    settle();

    // shrink below the used slots: their bits stay but are out of range
    write_reg(CFG_SLOTS_IN_USE, 64'd2);
    send_request(KIND_FREE, 64'd224);
    send_request(KIND_ALLOC, {$urandom, $urandom});
    send_request(KIND_FREE, 64'd32);
    settle();

    // base near the top of the address space, allocations wrap
    write_reg(CFG_SLAB_BASE, 64'hFFFF_FFFF_FFFF_FF00);
    write_reg(CFG_SLOTS_IN_USE, 64'd8);
    run_phase(25, 50);

    // zero chunk: one shared address, no free in range
    write_reg(CFG_CHUNK_BYTES, 64'd0);
    write_reg(CFG_SLAB_BASE, 64'h1000);
    write_reg(CFG_SLOTS_IN_USE, 64'd16);
    run_phase(25, 60);

    // header equal to or past the chunk size
    write_reg(CFG_CHUNK_BYTES, 64'd16);
    write_reg(CFG_HEADER_BYTES, 64'd16);
    run_phase(20, 50);
    write_reg(CFG_CHUNK_BYTES, 64'd8);
    write_reg(CFG_HEADER_BYTES, 64'd4096);
    run_phase(15, 50);

    write_reg(CFG_SLOTS_IN_USE, 64'd0);
    run_phase(15, 60);

    // all-ones data keeps only the low bits, unknown indexes do nothing
    write_reg(CFG_SLAB_BASE, {$urandom, $urandom});
    write_reg(CFG_CHUNK_BYTES, '1);
    write_reg(CFG_HEADER_BYTES, '1);
    write_reg(CFG_SLOTS_IN_USE, '1);
    write_reg(CFG_IDX_W'(CFG_SLOTS_IN_USE + 1), {$urandom, $urandom});
    write_reg('1, {$urandom, $urandom});
    run_phase(30, 50);

    hold_rsp = 1'b1;
    repeat (8) begin
      random_config();
      no_idle = ($urandom_range(0, 3) == 0);
      run_phase($urandom_range(35, 50), $urandom_range(25, 80));
    end
    no_idle = 1'b0;
    settle();

    if (ledger.errors == 0) begin
      $display("slab_bitmap_slot_allocator_core_tb OK");
    end else begin
      $display("slab_bitmap_slot_allocator_core_tb NOT OK");
    end
    $finish;
  end

endmodule
